// ===== hdl/assert_macros.svh =====
// assertion macros for the rtl files of the sliding window min/max unit
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SWMM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define SWMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/swmm_pkg.sv =====
// shared types and constants for the sliding window min/max unit
// no dependencies; used by swmm_ifs, swmm_deque and the top level
`timescale 1ns / 1ps
`default_nettype none

package swmm_pkg;

    // default parameter values
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // window size register
    localparam int                 CFG_W       = 7;
    localparam logic [CFG_W-1:0]   WSIZE_RESET = 7'd4;

    // running total
    localparam int                        TOTAL_W  = 48;
    localparam logic signed [TOTAL_W-1:0] TOTAL_HI = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [TOTAL_W-1:0] TOTAL_LO = 48'sh8000_0000_0000;

    // control from the top level to a deque
    typedef struct packed {
        logic start;
        logic clear;
    } t_dq_ctrl;

    // status from a deque to the top level
    typedef struct packed {
        logic busy;
    } t_dq_stat;

endpackage

`default_nettype wire

// ===== hdl/swmm_ifs.sv =====
// sample and result channel interfaces with valid/ready handshake
// depends on swmm_pkg for default widths
`timescale 1ns / 1ps
`default_nettype none

interface swmm_smp_if
    import swmm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface swmm_res_if
    import swmm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] window_max;
    logic signed [SAMPLE_BITS-1:0] window_min;
    logic signed [TOTAL_W-1:0]     running_total;
    logic                          window_complete;
    logic                          is_final;

    modport source (output valid, output window_max, output window_min,
                    output running_total, output window_complete, output is_final,
                    input ready);
    modport sink   (input valid, input window_max, input window_min,
                    input running_total, input window_complete, input is_final,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/swmm_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module swmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

`default_nettype wire

// ===== hdl/swmm_deque.sv =====
// one monotonic deque of (value, age tag) entries held in a ram
// depends on swmm_pkg and swmm_ram
`timescale 1ns / 1ps
`default_nettype none

module swmm_deque
    import swmm_pkg::*;
#(
    parameter int   WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int   SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter logic IS_MAX      = 1'b1
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire t_dq_ctrl                              i_ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0]         i_sample,
    input  wire logic [$clog2(2*WINDOW_MAX)-1:0]       i_pos,
    input  wire logic [$clog2(WINDOW_MAX+1)-1:0]       i_k,
    output t_dq_stat                                   o_stat,
    output logic signed [SAMPLE_BITS-1:0]              o_head_val
);
    localparam int AW      = $clog2(WINDOW_MAX);
    localparam int CW      = $clog2(WINDOW_MAX+1);
    localparam int PW      = $clog2(2*WINDOW_MAX);
    localparam int EW      = SAMPLE_BITS + PW;
    localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_MAX-1);
    localparam logic [PW:0]   POS_MOD  = (PW+1)'(2*WINDOW_MAX);

    localparam logic [1:0] DQ_IDLE  = 2'd0;
    localparam logic [1:0] DQ_FCHK  = 2'd1;
    localparam logic [1:0] DQ_BCHK  = 2'd2;
    localparam logic [1:0] DQ_WRITE = 2'd3;

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - 1'b1;
    endfunction

    logic [1:0]                    r_state, n_state;
    logic [AW-1:0]                 r_head, n_head;
    logic [AW-1:0]                 r_tail, n_tail;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic signed [SAMPLE_BITS-1:0] r_head_val, n_head_val;

    logic                          ram_we;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [EW-1:0]                 ram_rdata;
    logic signed [SAMPLE_BITS-1:0] rd_val;
    logic [PW-1:0]                 rd_tag;
    logic [PW:0]                   age;
    logic                          too_old;
    logic                          beats;

    swmm_ram #(
        .WIDTH (EW),
        .DEPTH (WINDOW_MAX)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata ({i_sample, i_pos}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_val = ram_rdata[EW-1:PW];
    assign rd_tag = ram_rdata[PW-1:0];

    // age modulo the position range
    assign age     = (i_pos >= rd_tag) ? ({1'b0, i_pos} - {1'b0, rd_tag})
                                       : ({1'b0, i_pos} + POS_MOD - {1'b0, rd_tag});
    assign too_old = (32'(age) >= 32'(i_k));
    assign beats   = IS_MAX ? (i_sample > rd_val) : (i_sample < rd_val);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_cnt      = r_cnt;
        n_head_val = r_head_val;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = r_head;
        case (r_state)
            DQ_IDLE: begin
                if (i_ctrl.clear) begin
                    n_head = '0;
                    n_tail = '0;
                    n_cnt  = '0;
                end else if (i_ctrl.start) begin
                    if (r_cnt == '0) begin
                        n_state = DQ_WRITE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_head;
                        n_state   = DQ_FCHK;
                    end
                end
            end
            DQ_FCHK: begin
                // drop expired entries from the front
                if (too_old) begin
                    n_head = idx_inc(r_head);
                    n_cnt  = r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        n_state = DQ_WRITE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_inc(r_head);
                    end
                end else begin
                    n_head_val = rd_val;
                    ram_re     = 1'b1;
                    ram_raddr  = idx_dec(r_tail);
                    n_state    = DQ_BCHK;
                end
            end
            DQ_BCHK: begin
                // drop dominated entries from the back
                if (beats) begin
                    n_tail = idx_dec(r_tail);
                    n_cnt  = r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        n_state = DQ_WRITE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_dec(idx_dec(r_tail));
                    end
                end else begin
                    n_state = DQ_WRITE;
                end
            end
            DQ_WRITE: begin
                // live entries are younger than the window, so the ram never overflows
                ram_we = 1'b1;
                n_tail = idx_inc(r_tail);
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == '0) begin
                    n_head_val = i_sample;
                end
                n_state = DQ_IDLE;
            end
            default: begin
                n_state = DQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DQ_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cnt   <= n_cnt;
        end
        r_head_val <= n_head_val;
    end

    assign o_stat.busy = (r_state != DQ_IDLE);
    assign o_head_val  = r_head_val;
endmodule

`default_nettype wire

// ===== hdl/sliding_window_min_max_sum_unit.sv =====
// sliding window min/max unit with saturating running total of max plus min
// depends on swmm_pkg, swmm_ifs, swmm_deque, swmm_ram and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

// Takes one signed sample per transaction on i_smp and tracks the maximum and
// minimum of the last window_size samples with two monotonic deques, each held
// in its own ram of WINDOW_MAX entries (value plus age tag). Once the window is
// full, each sample gives one result transaction on o_res with the window max,
// the window min and a running total of max plus min, saturating at the signed
// 48-bit range. A sample with last_sample set gives a result marked is_final
// and clears the stream state (window_size is kept); if the window never filled
// in the current stream, that final result carries zero max/min. Samples are
// handled one at a time: each passes through accept, front check, back check,
// deque write, a state that sees both deques done, and finish, with one more
// front or back check for each deque entry it pops; the two deques work in
// parallel, so the one with more pops sets the pace, and a deque that runs
// empty skips its remaining checks; for the first sample of a stream it goes
// straight to the deque write. Each pop needs its own check because the deque
// ram has registered read data and the next pop decision needs that read. A
// finished result waits in an output register, so a new sample is taken while
// it is unread; the block stalls only when a second result is ready before the
// first is taken. window_size must be written through i_cfg_we/i_cfg_wdata
// only while idle; the block itself does not enforce this. Zero acts as one and
// values above WINDOW_MAX act as WINDOW_MAX. No clearing pass is needed after reset.
module sliding_window_min_max_sum_unit
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    swmm_smp_if.sink              i_smp,
    swmm_res_if.source            o_res
);
    `include "assert_macros.svh"

    localparam int CW = $clog2(WINDOW_MAX+1);
    localparam int PW = $clog2(2*WINDOW_MAX);
    localparam logic [PW-1:0] LAST_POS = PW'(2*WINDOW_MAX-1);
    localparam logic [CW-1:0] CNT_MAX  = CW'(WINDOW_MAX);

    // top level sequencer
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]                    r_state, n_state;
    logic [CFG_W-1:0]              r_wsize;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_last;
    logic [PW-1:0]                 r_pos, n_pos;
    logic [CW-1:0]                 r_count, n_count;
    logic signed [TOTAL_W-1:0]     r_total, n_total;
    logic                          r_filled, n_filled;

    // output register
    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_max, n_out_max;
    logic signed [SAMPLE_BITS-1:0] r_out_min, n_out_min;
    logic signed [TOTAL_W-1:0]     r_out_total, n_out_total;
    logic                          r_out_cmpl, n_out_cmpl;
    logic                          r_out_final, n_out_final;

    logic [CW-1:0]                 win_k;
    logic                          accept;
    t_dq_ctrl                      dq_ctrl;
    t_dq_stat                      max_stat;
    t_dq_stat                      min_stat;
    logic signed [SAMPLE_BITS-1:0] max_head;
    logic signed [SAMPLE_BITS-1:0] min_head;
    logic [CW-1:0]                 count_inc;
    logic                          full;
    logic                          has_res;
    logic                          slot_free;
    logic signed [TOTAL_W:0]       sum_wide;
    logic signed [TOTAL_W-1:0]     sum_sat;

    // clamp window size into 1..WINDOW_MAX
    always_comb begin
        if (r_wsize == '0) begin
            win_k = CW'(1);
        end else if (32'(r_wsize) > WINDOW_MAX) begin
            win_k = CNT_MAX;
        end else begin
            win_k = CW'(r_wsize);
        end
    end

    assign accept      = i_smp.valid && i_smp.ready;
    assign i_smp.ready = (r_state == S_IDLE);

    swmm_deque #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IS_MAX      (1'b1)
    ) u_max_dq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (dq_ctrl),
        .i_sample   (r_sample),
        .i_pos      (r_pos),
        .i_k        (win_k),
        .o_stat     (max_stat),
        .o_head_val (max_head)
    );

    swmm_deque #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IS_MAX      (1'b0)
    ) u_min_dq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (dq_ctrl),
        .i_sample   (r_sample),
        .i_pos      (r_pos),
        .i_k        (win_k),
        .o_stat     (min_stat),
        .o_head_val (min_head)
    );

    // count saturates at the deque depth
    assign count_inc = (r_count == CNT_MAX) ? r_count : r_count + 1'b1;
    assign full      = (count_inc >= win_k);
    assign has_res   = full || r_last;
    assign slot_free = !r_out_valid || o_res.ready;

    // saturating add of max plus min into the total
    assign sum_wide = (TOTAL_W+1)'(r_total) + (TOTAL_W+1)'(max_head)
                    + (TOTAL_W+1)'(min_head);
    always_comb begin
        if (sum_wide[TOTAL_W] != sum_wide[TOTAL_W-1]) begin
            sum_sat = sum_wide[TOTAL_W] ? TOTAL_LO : TOTAL_HI;
        end else begin
            sum_sat = sum_wide[TOTAL_W-1:0];
        end
    end

    always_comb begin
        n_state       = r_state;
        n_pos         = r_pos;
        n_count       = r_count;
        n_total       = r_total;
        n_filled      = r_filled;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_out_max     = r_out_max;
        n_out_min     = r_out_min;
        n_out_total   = r_out_total;
        n_out_cmpl    = r_out_cmpl;
        n_out_final   = r_out_final;
        dq_ctrl.start = 1'b0;
        dq_ctrl.clear = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    dq_ctrl.start = 1'b1;
                    n_state       = S_RUN;
                end
            end
            S_RUN: begin
                // both deques run in parallel; wait for the slower one
                if (!max_stat.busy && !min_stat.busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!has_res || slot_free) begin
                    n_pos   = (r_pos == LAST_POS) ? '0 : r_pos + 1'b1;
                    n_count = count_inc;
                    if (full) begin
                        n_total  = sum_sat;
                        n_filled = 1'b1;
                    end
                    // the output register is only touched when a result is made
                    if (has_res) begin
                        n_out_valid = 1'b1;
                        n_out_final = r_last;
                        if (full) begin
                            n_out_max   = max_head;
                            n_out_min   = min_head;
                            n_out_total = sum_sat;
                            n_out_cmpl  = 1'b1;
                        end else begin
                            // stream ended before the window filled
                            n_out_max   = '0;
                            n_out_min   = '0;
                            n_out_total = r_total;
                            n_out_cmpl  = r_filled;
                        end
                    end
                    if (r_last) begin
                        dq_ctrl.clear = 1'b1;
                        n_pos         = '0;
                        n_count       = '0;
                        n_total       = '0;
                        n_filled      = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wsize     <= WSIZE_RESET;
            r_pos       <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_filled    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_total     <= n_total;
            r_filled    <= n_filled;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_wsize <= i_cfg_wdata;
            end
        end
        if (accept) begin
            r_sample <= i_smp.sample;
            r_last   <= i_smp.last_sample;
        end
        r_out_max   <= n_out_max;
        r_out_min   <= n_out_min;
        r_out_total <= n_out_total;
        r_out_cmpl  <= n_out_cmpl;
        r_out_final <= n_out_final;
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.window_max      = r_out_max;
    assign o_res.window_min      = r_out_min;
    assign o_res.running_total   = r_out_total;
    assign o_res.window_complete = r_out_cmpl;
    assign o_res.is_final        = r_out_final;

    // checks
    `SWMM_ASSERT_IMPL(a_max_ge_min, i_clk, i_rst_n, o_res.valid, o_res.window_max >= o_res.window_min)
    `SWMM_ASSERT_IMPL(a_accept_dq_idle, i_clk, i_rst_n, accept, !max_stat.busy && !min_stat.busy)
    `SWMM_ASSERT_NEXT(a_accept_runs, i_clk, i_rst_n, accept, r_state == S_RUN)
    `SWMM_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_MAX)

endmodule

`default_nettype wire
